/* sv/cstr_pkg.sv */
package cstr_pkg;

  localparam int NUM_CHARSETS = 8;
  localparam int CS_W = 3;
  localparam int UNI_W = 21;
  localparam int MAP_AW = CS_W + 8;
  localparam int MAP_DEPTH = NUM_CHARSETS * 256;
  localparam int CODE_DEPTH = 256;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_ENC  = 2'd1;
  localparam logic [1:0] MODE_DEC  = 2'd2;
  localparam logic [1:0] MODE_BAD  = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_ILLEGAL     = 3'd1;
  localparam logic [2:0] ST_OVERFLOW    = 3'd2;
  localparam logic [2:0] ST_UNHANDLED   = 3'd3;
  localparam logic [2:0] ST_NODEFAULT   = 3'd4;
  localparam logic [2:0] ST_INFILTRATED = 3'd5;

  localparam logic CFG_RELAX   = 1'b0;
  localparam logic CFG_DEFAULT = 1'b1;

  typedef struct packed {
    logic [1:0]       mode;
    logic [CS_W-1:0]  charset;
    logic [7:0]       data_byte;
    logic [UNI_W-1:0] unicode;
    logic             allocate;
    logic             unhandled;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

/* sv/cstr_ram.sv */
module cstr_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/cstr_front.sv */
module cstr_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               mode_i,
  input  logic [cstr_pkg::CS_W-1:0] charset_i,
  input  logic [7:0]               data_byte_i,
  input  logic [cstr_pkg::UNI_W-1:0] unicode_i,
  input  logic                     allocate_i,
  input  logic                     init_done_i,
  input  logic                     pop_i,
  output cstr_pkg::head_t          head_o
);

  cstr_pkg::item_t slot_q [2];
  cstr_pkg::item_t item;
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;
  logic            push;
  logic            pop;

  // classify: bad mode or charset out of range is unhandled
  always_comb begin
    item.mode      = mode_i;
    item.charset   = charset_i;
    item.data_byte = data_byte_i;
    item.unicode   = unicode_i;
    item.allocate  = allocate_i;
    item.unhandled = (mode_i == cstr_pkg::MODE_BAD) ||
                     ({1'b0, charset_i} >= (cstr_pkg::CS_W+1)'(cstr_pkg::NUM_CHARSETS));
  end

  assign in_ready_o = init_done_i && (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign pop  = pop_i && (cnt_q != 2'd0);

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = slot_q[rp_q];

endmodule

/* sv/cstr_back.sv */
module cstr_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cstr_pkg::head_t      head_i,
  output logic                 pop_o,
  output logic                 init_done_o,
  input  logic                 relax_i,
  input  logic [7:0]           dchar_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           code_o,
  output logic [2:0]           status_o,
  output logic [8:0]           allocated_count_o
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_EVAL  = 4'd2;
  localparam logic [3:0] S_DEF   = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_SCANE = 4'd5;
  localparam logic [3:0] S_APPLY = 4'd6;
  localparam logic [3:0] S_RES   = 4'd7;

  localparam int AW  = cstr_pkg::MAP_AW;
  localparam int UW  = cstr_pkg::UNI_W;

  logic [3:0]      state_q, state_d;
  logic [AW:0]     init_q, init_d;
  cstr_pkg::item_t item_q, item_d;
  logic [UW-1:0]   tgt_q, tgt_d;
  logic            hfree_q, hfree_d;
  logic            hit_f_q, hit_f_d, free_f_q, free_f_d;
  logic [7:0]      hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic            chk_v_q, chk_v_d;
  logic [7:0]      chk_idx_q, chk_idx_d;
  logic [7:0]      scan_q, scan_d;
  logic [7:0]      res_code_q, res_code_d;
  logic [2:0]      res_st_q, res_st_d;
  logic            out_v_q, out_v_d;
  logic [7:0]      out_code_q, out_code_d;
  logic [2:0]      out_st_q, out_st_d;
  logic [8:0]      out_cnt_q, out_cnt_d;
  logic [8:0]      used_q, used_d;

  logic            em_we, dm_we, cu_we, iu_we;
  logic [AW-1:0]   em_wa, dm_wa, cu_wa, em_ra, dm_ra, cu_ra;
  logic [7:0]      iu_wa, iu_ra;
  logic [7:0]      em_wd, dm_wd, em_rd, dm_rd;
  logic [UW-1:0]   cu_wd, iu_wd, cu_rd, iu_rd;

  logic [UW-1:0]   u_alloc;
  logic [7:0]      b;
  logic            found;
  logic [7:0]      h;
  logic            init_id;

  cstr_ram #(.Width(8), .Depth(cstr_pkg::MAP_DEPTH)) u_em (
    .clk_i, .we_i(em_we), .waddr_i(em_wa), .wdata_i(em_wd), .raddr_i(em_ra), .rdata_o(em_rd)
  );
  cstr_ram #(.Width(8), .Depth(cstr_pkg::MAP_DEPTH)) u_dm (
    .clk_i, .we_i(dm_we), .waddr_i(dm_wa), .wdata_i(dm_wd), .raddr_i(dm_ra), .rdata_o(dm_rd)
  );
  cstr_ram #(.Width(UW), .Depth(cstr_pkg::MAP_DEPTH)) u_cu (
    .clk_i, .we_i(cu_we), .waddr_i(cu_wa), .wdata_i(cu_wd), .raddr_i(cu_ra), .rdata_o(cu_rd)
  );
  cstr_ram #(.Width(UW), .Depth(cstr_pkg::CODE_DEPTH)) u_iu (
    .clk_i, .we_i(iu_we), .waddr_i(iu_wa), .wdata_i(iu_wd), .raddr_i(iu_ra), .rdata_o(iu_rd)
  );

  assign b = item_q.data_byte;
  assign init_id = (init_q < (AW+1)'(128));

  // empty charset entry: take the byte as unicode if its hint code holds it or, below 32, is free
  assign u_alloc = ((cu_rd == '0) &&
                    (((b < 8'd32) && (iu_rd == '0)) || (iu_rd == UW'(b)))) ? UW'(b) : cu_rd;

  assign found = hit_f_q && (hit_idx_q != 8'd0);
  assign h = found ? hit_idx_q : (hfree_q ? b : free_idx_q);

  // read addresses: head item while idle, default char or scan index later
  assign em_ra = (state_q == S_IDLE) ? {head_i.item.charset, head_i.item.data_byte}
                                     : {item_q.charset, dchar_i};
  assign dm_ra = {head_i.item.charset, head_i.item.data_byte};
  assign cu_ra = {head_i.item.charset, head_i.item.data_byte};
  assign iu_ra = (state_q == S_IDLE) ? head_i.item.data_byte : scan_q;

  always_comb begin
    state_d    = state_q;
    init_d     = init_q;
    item_d     = item_q;
    tgt_d      = tgt_q;
    hfree_d    = hfree_q;
    hit_f_d    = hit_f_q;
    hit_idx_d  = hit_idx_q;
    free_f_d   = free_f_q;
    free_idx_d = free_idx_q;
    chk_v_d    = chk_v_q;
    chk_idx_d  = chk_idx_q;
    scan_d     = scan_q;
    res_code_d = res_code_q;
    res_st_d   = res_st_q;
    out_v_d    = out_v_q && !out_ready_i;
    out_code_d = out_code_q;
    out_st_d   = out_st_q;
    out_cnt_d  = out_cnt_q;
    used_d     = used_q;
    pop_o      = 1'b0;
    em_we = 1'b0; dm_we = 1'b0; cu_we = 1'b0; iu_we = 1'b0;
    em_wa = {item_q.charset, b};
    dm_wa = {item_q.charset, h};
    cu_wa = {item_q.charset, b};
    iu_wa = h;
    em_wd = h;
    dm_wd = b;
    cu_wd = tgt_q;
    iu_wd = tgt_q;

    // priority compare of the scanned entry: first hit from the top wins
    if (chk_v_q) begin
      if (!hit_f_q && (iu_rd == tgt_q)) begin
        hit_f_d   = 1'b1;
        hit_idx_d = chk_idx_q;
      end
      if (!free_f_q && (iu_rd == '0) && (chk_idx_q != 8'd0)) begin
        free_f_d   = 1'b1;
        free_idx_d = chk_idx_q;
      end
    end

    case (state_q)
      S_INIT: begin
        em_we = 1'b1; dm_we = 1'b1; cu_we = 1'b1;
        em_wa = init_q[AW-1:0];
        dm_wa = init_q[AW-1:0];
        cu_wa = init_q[AW-1:0];
        em_wd = init_id ? init_q[7:0] : 8'd0;
        dm_wd = init_id ? init_q[7:0] : 8'd0;
        cu_wd = init_id ? UW'(init_q[7:0]) : '0;
        iu_we = (init_q < (AW+1)'(cstr_pkg::CODE_DEPTH));
        iu_wa = init_q[7:0];
        iu_wd = '0;
        init_d = init_q + 1'b1;
        if (init_q == (AW+1)'(cstr_pkg::MAP_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          item_d  = head_i.item;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        res_code_d = 8'd0;
        res_st_d   = cstr_pkg::ST_OK;
        state_d    = S_RES;
        hit_f_d    = 1'b0;
        hit_idx_d  = 8'd0;
        free_f_d   = 1'b0;
        free_idx_d = 8'd0;
        chk_v_d    = 1'b0;
        scan_d     = 8'd255;
        if (item_q.unhandled) begin
          res_st_d = cstr_pkg::ST_UNHANDLED;
        end else begin
          case (item_q.mode)
            cstr_pkg::MODE_DEC: begin
              if ((dm_rd == 8'd0) && (b != 8'd0)) res_st_d = cstr_pkg::ST_INFILTRATED;
              else res_code_d = dm_rd;
            end
            cstr_pkg::MODE_ENC: begin
              if ((em_rd != 8'd0) || (b == 8'd0)) begin
                res_code_d = em_rd;
              end else if (item_q.allocate) begin
                tgt_d   = u_alloc;
                hfree_d = (iu_rd == '0);
                if (u_alloc == '0) begin
                  res_st_d = cstr_pkg::ST_ILLEGAL;
                end else if (iu_rd == u_alloc) begin
                  hit_f_d   = 1'b1;
                  hit_idx_d = b;
                  state_d   = S_APPLY;
                end else begin
                  state_d = S_SCAN;
                end
              end else if (relax_i) begin
                state_d = S_DEF;
              end else begin
                res_st_d = cstr_pkg::ST_UNHANDLED;
              end
            end
            cstr_pkg::MODE_LOAD: begin
              tgt_d = item_q.unicode;
              if (iu_rd == item_q.unicode) begin
                hit_f_d   = 1'b1;
                hit_idx_d = b;
                state_d   = S_APPLY;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: res_st_d = cstr_pkg::ST_UNHANDLED;
          endcase
        end
      end
      S_DEF: begin
        if (em_rd == 8'd0) res_st_d = cstr_pkg::ST_NODEFAULT;
        else res_code_d = em_rd;
        state_d = S_RES;
      end
      S_SCAN: begin
        chk_v_d   = 1'b1;
        chk_idx_d = scan_q;
        if (scan_q == 8'd0) state_d = S_SCANE;
        else scan_d = scan_q - 8'd1;
      end
      S_SCANE: begin
        chk_v_d = 1'b0;
        state_d = S_APPLY;
      end
      S_APPLY: begin
        state_d = S_RES;
        if (item_q.mode == cstr_pkg::MODE_LOAD) begin
          cu_we = 1'b1;
          em_wd = hit_idx_q;
          dm_wa = {item_q.charset, hit_idx_q};
          em_we = (hit_idx_q != 8'd0);
          dm_we = (hit_idx_q != 8'd0);
          res_code_d = hit_idx_q;
        end else if (!found && !hfree_q && !free_f_q) begin
          res_st_d = cstr_pkg::ST_OVERFLOW;
        end else begin
          iu_we = 1'b1;
          em_we = 1'b1;
          dm_we = 1'b1;
          if (!found) used_d = used_q + 9'd1;
          res_code_d = h;
        end
      end
      S_RES: begin
        if (!out_v_q || out_ready_i) begin
          out_v_d    = 1'b1;
          out_code_d = res_code_q;
          out_st_d   = res_st_q;
          out_cnt_d  = used_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    tgt_q      <= tgt_d;
    hfree_q    <= hfree_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    chk_idx_q  <= chk_idx_d;
    scan_q     <= scan_d;
    res_code_q <= res_code_d;
    res_st_q   <= res_st_d;
    out_code_q <= out_code_d;
    out_st_q   <= out_st_d;
    out_cnt_q  <= out_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      init_q   <= '0;
      hit_f_q  <= 1'b0;
      free_f_q <= 1'b0;
      chk_v_q  <= 1'b0;
      out_v_q  <= 1'b0;
      used_q   <= 9'd0;
    end else begin
      state_q  <= state_d;
      init_q   <= init_d;
      hit_f_q  <= hit_f_d;
      free_f_q <= free_f_d;
      chk_v_q  <= chk_v_d;
      out_v_q  <= out_v_d;
      used_q   <= used_d;
    end
  end

  assign init_done_o       = (state_q != S_INIT);
  assign out_valid_o       = out_v_q;
  assign code_o            = out_code_q;
  assign status_o          = out_st_q;
  assign allocated_count_o = out_cnt_q;

  a_err_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> ((out_st_q == cstr_pkg::ST_OK) || (out_code_q == 8'd0)))
    else $error("error result carries nonzero code");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= 9'd255)
    else $error("allocated count exceeds code space");

  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> (used_q == $past(used_q) + 9'd1))
    else $error("allocated count jumped");

  a_no_pop_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> !pop_o)
    else $error("item taken during clearing pass");

endmodule

/* sv/charset_translate_with_code_alloc_unit.sv */
// Charset translator with a shared 256-entry internal code space.
//
// Input channel (in_valid_i/in_ready_o) takes one item per handshake: mode,
// charset, data_byte, unicode, allocate. Output channel (out_valid_o/
// out_ready_i) returns exactly one item per input: code, status and the
// allocated code count after that item.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 relaxed-input flag, 1 replacement byte); write only while idle.
//
// Path to out_valid_o: an item is popped in S_IDLE, evaluated in S_EVAL and
// its result registered in S_RES; map hits, decodes and early errors go
// straight there. A relaxed default lookup passes S_DEF, and an item whose
// hint code already holds the unicode value passes S_APPLY. Loads and
// allocating encodes that miss the hint scan the internal table one entry per
// cycle. The back end works on one item at a time; a two-entry front queue
// keeps accepting items while it works or while a finished result waits for
// out_ready_i; when both are full, in_ready_o drops.
// Reset: a clearing pass over the 2048 map entries loads the charset maps
// (charset 0 ASCII identity) and zeroes the internal table; no item is taken
// until it ends. Configuration writes are taken throughout.
module charset_translate_with_code_alloc_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [2:0]  charset_i,
  input  logic [7:0]  data_byte_i,
  input  logic [20:0] unicode_i,
  input  logic        allocate_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  code_o,
  output logic [2:0]  status_o,
  output logic [8:0]  allocated_count_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  logic            relax_q, relax_d;
  logic [7:0]      dchar_q, dchar_d;
  cstr_pkg::head_t head;
  logic            pop;
  logic            init_done;

  // hold configuration; update only on a write strobe
  always_comb begin
    relax_d = relax_q;
    dchar_d = dchar_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        cstr_pkg::CFG_RELAX:   relax_d = cfg_data_i[0];
        cstr_pkg::CFG_DEFAULT: dchar_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relax_q <= 1'b0;
      dchar_q <= 8'd0;
    end else begin
      relax_q <= relax_d;
      dchar_q <= dchar_d;
    end
  end

  // front: accept, classify, queue
  cstr_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .mode_i,
    .charset_i,
    .data_byte_i,
    .unicode_i,
    .allocate_i,
    .init_done_i (init_done),
    .pop_i       (pop),
    .head_o      (head)
  );

  // back: map lookups, code search and allocation, result register
  cstr_back u_back (
    .clk_i,
    .rst_ni,
    .head_i            (head),
    .pop_o             (pop),
    .init_done_o       (init_done),
    .relax_i           (relax_q),
    .dchar_i           (dchar_q),
    .out_valid_o,
    .out_ready_i,
    .code_o,
    .status_o,
    .allocated_count_o
  );

endmodule
